/* design/ralseq_pkg.sv */
// ----------------------------------------------------------------------------
// ralseq_pkg
// shared constants and instruction encoders for the address load sequencer
// ----------------------------------------------------------------------------
package ralseq_pkg;

  localparam int unsigned NumWords = 6;

  localparam logic [6:0] OpcLui   = 7'h37;
  localparam logic [6:0] OpcOpImm = 7'h13;
  localparam logic [2:0] F3Addi   = 3'd0;
  localparam logic [2:0] F3Slli   = 3'd1;
  localparam logic [11:0] SlliImm = 12'd12;

  typedef logic [31:0] word_t;
  typedef word_t [NumWords-1:0] word_list_t;
  typedef logic [NumWords-1:0] word_mask_t;

  function automatic word_t enc_lui(logic [4:0] rd, logic [19:0] imm20);
    return {imm20, rd, OpcLui};
  endfunction

  function automatic word_t enc_addi(logic [4:0] rd, logic [11:0] imm12);
    return {imm12, rd, F3Addi, rd, OpcOpImm};
  endfunction

  function automatic word_t enc_slli12(logic [4:0] rd);
    return {SlliImm, rd, F3Slli, rd, OpcOpImm};
  endfunction

endpackage

/* design/riscv_address_load_sequence.sv */
// ----------------------------------------------------------------------------
// riscv_address_load_sequence
// emits the lui/addi/slli words that load a 64-bit address into a register
// ----------------------------------------------------------------------------
// a transaction passes through stages a, b and c to the output sequencer,
// which sends its words one per cycle; a new transaction can be taken while
//   earlier ones are in flight, and busy holds start off when stages are full
// reset: rst_ni clears all valid bits and the mode register to rv64
// the receiver cannot stall; words leave one per cycle marked by word_valid_o
module riscv_address_load_sequence (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  dest_reg_i,
  input  logic [63:0] target_address_i,
  output logic        word_valid_o,
  output ralseq_pkg::word_t instruction_word_o,
  output logic        last_word_o
);
  import ralseq_pkg::*;

  logic mode_q;

  // stage a: captured transaction
  logic        a_v_q;
  logic [4:0]  a_rd_q;
  logic [63:0] a_addr_q;
  logic        a_mode_q;
  logic [51:0] a_t;

  // stage b: upper part with low 12 bits rounded in
  logic        b_v_q;
  logic [4:0]  b_rd_q;
  logic        b_mode_q;
  logic [11:0] b_lo_q;
  logic [51:0] b_t_q;
  logic        b_short;
  logic [31:0] b_u;

  // stage c: split parts, word build
  logic        c_v_q;
  logic [4:0]  c_rd_q;
  logic        c_short_q;
  logic [11:0] c_lo_q;
  logic [19:0] c_lui_q;
  logic [11:0] c_mid12_q;
  logic [31:0] c_u_q;
  logic [19:0] c_hi20;
  logic [11:0] c_mid20;
  word_list_t  c_words;
  word_mask_t  c_mask;

  // output sequencer
  logic        e_v_q;
  word_list_t  e_words_q;
  word_mask_t  e_mask_q;
  word_mask_t  e_pick;
  word_mask_t  e_rest;
  logic        e_last;

  logic a_ready, b_ready, c_ready, e_ready;

  assign e_rest  = e_mask_q & (e_mask_q - word_mask_t'(1));
  assign e_pick  = e_mask_q & ~e_rest;
  assign e_last  = (e_rest == '0);
  assign e_ready = !e_v_q || e_last;
  assign c_ready = !c_v_q || e_ready;
  assign b_ready = !b_v_q || c_ready;
  assign a_ready = !a_v_q || b_ready;
  assign busy    = !a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (a_ready) begin
        a_v_q <= start;
      end
      if (b_ready) begin
        b_v_q <= a_v_q;
      end
      if (c_ready) begin
        c_v_q <= b_v_q;
      end
      if (e_ready) begin
        e_v_q <= c_v_q;
      end
    end
  end

  // address minus its sign-extended low 12 bits, low 12 bits dropped
  assign a_t = a_addr_q[63:12] + 52'(a_addr_q[11]);

  // sign-extension rule of lui
  assign b_short = (&b_t_q[51:19]) || !(|b_t_q[51:19]);
  assign b_u     = b_t_q[43:12] + 32'(b_t_q[11]);

  assign c_mid20 = c_u_q[11:0];
  assign c_hi20  = c_u_q[31:12] + 20'(c_u_q[11]);

  always_comb begin
    c_words = '0;
    c_mask  = '0;
    if (c_short_q) begin
      c_words[0] = enc_lui(c_rd_q, c_lui_q);
      c_words[1] = enc_addi(c_rd_q, c_lo_q);
      c_mask[0]  = 1'b1;
      c_mask[1]  = (c_lo_q != '0);
    end else begin
      c_words[0] = enc_lui(c_rd_q, c_hi20);
      c_words[1] = enc_addi(c_rd_q, c_mid20);
      c_words[2] = enc_slli12(c_rd_q);
      c_words[3] = enc_addi(c_rd_q, c_mid12_q);
      c_words[4] = enc_slli12(c_rd_q);
      c_words[5] = enc_addi(c_rd_q, c_lo_q);
      c_mask[0]  = 1'b1;
      c_mask[1]  = (c_mid20 != '0);
      c_mask[2]  = 1'b1;
      c_mask[3]  = (c_mid12_q != '0);
      c_mask[4]  = 1'b1;
      c_mask[5]  = (c_lo_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && a_ready) begin
      a_rd_q   <= dest_reg_i;
      a_addr_q <= target_address_i;
      a_mode_q <= mode_q;
    end
    if (a_v_q && b_ready) begin
      b_rd_q   <= a_rd_q;
      b_mode_q <= a_mode_q;
      b_lo_q   <= a_addr_q[11:0];
      b_t_q    <= a_t;
    end
    if (b_v_q && c_ready) begin
      c_rd_q    <= b_rd_q;
      c_short_q <= b_mode_q || b_short;
      c_lo_q    <= b_lo_q;
      c_lui_q   <= b_t_q[19:0];
      c_mid12_q <= b_t_q[11:0];
      c_u_q     <= b_u;
    end
    if (e_ready) begin
      e_words_q <= c_words;
      e_mask_q  <= c_mask;
    end else begin
      e_mask_q <= e_rest;
    end
  end

  always_comb begin
    instruction_word_o = '0;
    for (int i = 0; i < NumWords; i++) begin
      if (e_pick[i]) begin
        instruction_word_o = instruction_word_o | e_words_q[i];
      end
    end
  end

  assign word_valid_o = e_v_q;
  assign last_word_o  = e_last;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the risc-v address load sequencer
//
// drives register/address transactions through the start/busy handshake and
// predicts the lui/addi/slli words for each one in rv64 and rv32 mode. every
// word strobed out is checked in order against the prediction. the mode
// register is switched only while the block is drained. a directed set of
// corner addresses comes first, then random addresses with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ralseq_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [1:0] {
    WordLui,
    WordAddi,
    WordSlli
  } word_kind_e;

  typedef struct packed {
    word_t insn;
    logic  is_last;
  } load_word_t;

  class addr_load_scoreboard;
    bit          rv32;
    load_word_t  load_words_due[$];
    int unsigned errors;

    function word_t encode(word_kind_e kind, logic [4:0] rd, logic [19:0] imm);
      case (kind)
        WordLui:  return {imm, rd, OpcLui};
        WordAddi: return {imm[11:0], rd, F3Addi, rd, OpcOpImm};
        default:  return {SlliImm, rd, F3Slli, rd, OpcOpImm};
      endcase
    endfunction

    function logic [63:0] sign_extend12(logic [11:0] v);
      return {{52{v[11]}}, v};
    endfunction

    // works out the word sequence for one accepted transaction
    function void note_item(logic [4:0] rd, logic [63:0] addr);
      word_t       words [NumWords];
      int          n;
      logic [63:0] lo, t, a, mid12, mid20;
      logic [31:0] t32;
      load_word_t  e;
      n = 0;
      lo = sign_extend12(addr[11:0]);
      if (rv32) begin
        t32 = addr[31:0] - lo[31:0];
        words[n] = encode(WordLui, rd, t32[31:12]);
        n++;
        if (lo[11:0] != 12'd0) begin
          words[n] = encode(WordAddi, rd, {8'd0, lo[11:0]});
          n++;
        end
      end else begin
        t = addr - lo;
        if (t + 64'h0000_0000_8000_0000 < 64'h0000_0001_0000_0000) begin
          words[n] = encode(WordLui, rd, t[31:12]);
          n++;
          if (lo[11:0] != 12'd0) begin
            words[n] = encode(WordAddi, rd, {8'd0, lo[11:0]});
            n++;
          end
        end else begin
          a = t;
          mid12 = sign_extend12(a[23:12]);
          a = a - (mid12 << 12);
          mid20 = sign_extend12(a[35:24]);
          a = a - (mid20 << 24);
          words[n] = encode(WordLui, rd, a[55:36]);
          n++;
          if (mid20[11:0] != 12'd0) begin
            words[n] = encode(WordAddi, rd, {8'd0, mid20[11:0]});
            n++;
          end
          words[n] = encode(WordSlli, rd, 20'd0);
          n++;
          if (mid12[11:0] != 12'd0) begin
            words[n] = encode(WordAddi, rd, {8'd0, mid12[11:0]});
            n++;
          end
          words[n] = encode(WordSlli, rd, 20'd0);
          n++;
          if (lo[11:0] != 12'd0) begin
            words[n] = encode(WordAddi, rd, {8'd0, lo[11:0]});
            n++;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        e.insn = words[i];
        e.is_last = (i == n - 1);
        load_words_due.push_back(e);
      end
    endfunction

    function void check_word(word_t insn, logic is_last);
      load_word_t e;
      if (load_words_due.size() == 0) begin
        $error("instruction_word unexpected: expected none, actual %h", insn);
        errors++;
        return;
      end
      e = load_words_due.pop_front();
      if (insn !== e.insn) begin
        $error("instruction_word mismatch: expected %h, actual %h", e.insn, insn);
        errors++;
      end
      if (is_last !== e.is_last) begin
        $error("last_word mismatch: expected %b, actual %b", e.is_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return load_words_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [4:0]  dest_reg_i;
  logic [63:0] target_address_i;
  logic        word_valid_o;
  word_t       instruction_word_o;
  logic        last_word_o;

  addr_load_scoreboard sb;
  bit          no_idle;
  int unsigned idle_cycles;

  riscv_address_load_sequence dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start              (start),
    .busy               (busy),
    .dest_reg_i         (dest_reg_i),
    .target_address_i   (target_address_i),
    .word_valid_o       (word_valid_o),
    .instruction_word_o (instruction_word_o),
    .last_word_o        (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && word_valid_o) begin
      sb.check_word(instruction_word_o, last_word_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || word_valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] random_address();
    logic [63:0] r;
    logic [11:0] grp;
    int          sel;
    r = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
      end
      2: r = {{32{r[31]}}, r[31:0]};
      3: r = {{52{r[11]}}, r[11:0]};
      4, 5: r = {{8{r[55]}}, r[55:0]};
      6: begin
        case ($urandom_range(0, 3))
          0:       r = 64'h0000_0000_7fff_f800;
          1:       r = 64'hffff_ffff_7fff_f800;
          2:       r = 64'hffff_ffff_8000_0800;
          default: r = 64'h0000_0000_8000_0000;
        endcase
        r = r + 64'($urandom_range(0, 4)) - 64'd2;
      end
      default: begin
        // low 12-bit groups set to zero, sign boundaries, all ones or random values
        for (int g = 0; g < 4; g++) begin
          case ($urandom_range(0, 4))
            0:       grp = 12'h000;
            1:       grp = 12'h7ff;
            2:       grp = 12'h800;
            3:       grp = 12'hfff;
            default: grp = 12'($urandom);
          endcase
          r[g*12 +: 12] = grp;
        end
        if (sel != 9) begin
          r = {{8{r[55]}}, r[55:0]};
        end
      end
    endcase
    return r;
  endfunction

  // holds start until the transaction is taken, leaves start high afterward only when gap is zero
  task automatic drive_item(logic [4:0] rd, logic [63:0] addr, int gap);
    start <= 1'b1;
    dest_reg_i <= rd;
    target_address_i <= addr;
    do begin
      @(posedge clk_i);
    end while (busy);
    sb.note_item(rd, addr);
    if (gap > 0) begin
      start <= 1'b0;
      dest_reg_i <= 5'($urandom);
      target_address_i <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(bit rv32);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= rv32;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.rv32 = rv32;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      drive_item(5'($urandom_range(0, 31)), random_address(), pick_gap());
    end
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    start = 1'b0;
    dest_reg_i = 5'd0;
    target_address_i = 64'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    drive_item(5'd0,  64'h0000_0000_0000_0000, pick_gap());
    drive_item(5'd31, 64'hffff_ffff_ffff_ffff, pick_gap());
    drive_item(5'd5,  64'h0000_0000_0000_07ff, pick_gap());
    drive_item(5'd6,  64'h0000_0000_0000_0800, pick_gap());
    drive_item(5'd7,  64'h0000_0000_7fff_f7ff, pick_gap());
    drive_item(5'd8,  64'h0000_0000_7fff_f800, pick_gap());
    drive_item(5'd9,  64'hffff_ffff_8000_0000, pick_gap());
    drive_item(5'd10, 64'hffff_ffff_7fff_f7ff, pick_gap());
    drive_item(5'd11, 64'h0000_0010_0000_0000, pick_gap());
    drive_item(5'd12, 64'h0012_3456_789a_bcde, pick_gap());
    drive_item(5'd13, 64'h8000_0000_0000_0000, pick_gap());
    drive_item(5'd14, 64'h7fff_ffff_ffff_ffff, pick_gap());
    drive_item(5'd15, 64'h0100_0000_0000_0000, pick_gap());
    drive_item(5'd31, 64'hff80_0000_0000_0800, pick_gap());
    drain();

    write_mode(1'b1);
    drive_item(5'd0,  64'h0000_0000_0000_0000, pick_gap());
    drive_item(5'd31, 64'hffff_ffff_ffff_ffff, pick_gap());
    drive_item(5'd3,  64'h1234_5678_7fff_f800, pick_gap());
    drive_item(5'd4,  64'hdead_beef_0000_0800, pick_gap());
    drive_item(5'd16, 64'h0000_0000_ffff_f7ff, pick_gap());
    drive_item(5'd17, 64'h5555_5555_aaaa_a000, pick_gap());
    drain();

    write_mode(1'b0);
    run_random(160);
    drain();
    write_mode(1'b1);
    run_random(110);
    drain();
    write_mode(1'b0);
    run_random(150);
    drain();

    if (sb.pending() != 0) begin
      $error("instruction_word missing: %0d expected words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ralseq_pkg.sv
design/riscv_address_load_sequence.sv
sim/tb_top.sv
